### design/dma_burst_splitter_assert.svh
// assertion macros used by the checker file dbs_checker.sv
`ifndef DMA_BURST_SPLITTER_ASSERT_SVH
`define DMA_BURST_SPLITTER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define DBS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dbs assertion failed");

// next-cycle implication, disabled in reset
`define DBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dbs assertion failed");

`endif

### design/dbs_pkg.sv
`default_nettype none
package dbs_pkg;

  localparam int MAX_REQUEST_BYTES = 4096;
  localparam int MAX_OUTSTANDING   = 63;

  localparam int LEN_W     = 13;
  localparam int CNT_W     = 32;
  localparam int ADDR_W    = 64;
  localparam int OUTST_W   = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 13;
  localparam int DIV_STEPS = CNT_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [1:0] KIND_REQ  = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_BUSY = 2'd2;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_RESP  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_REQUEST_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_OUTSTANDING = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_IS_PIM   = 2'd2;

  localparam logic [LEN_W-1:0]   RESET_REQUEST_SIZE    = 13'd64;
  localparam logic [OUTST_W-1:0] RESET_MAX_OUTSTANDING = 6'd16;

  typedef struct packed {
    logic             command;
    logic             direction;
    logic [CNT_W-1:0] byte_count;
  } dbs_in_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic              request_dir;
    logic [ADDR_W-1:0] request_address;
    logic [LEN_W-1:0]  request_length;
    logic [CNT_W-1:0]  request_index;
    logic [CNT_W-1:0]  request_total;
    logic              destination;
    logic              last;
  } dbs_out_t;

  typedef struct packed {
    logic start;
    logic div_step;
    logic div_fix;
    logic resp;
    logic clear_busy;
    logic emit_req;
    logic emit_done;
    logic emit_busy;
  } dbs_cmd_t;

  typedef struct packed {
    logic busy;
    logic outst_nz;
    logic outst_one;
    logic left_zero;
    logic bytes_zero;
    logic div_last;
    logic can_issue;
    logic req_last;
    logic out_free;
  } dbs_sts_t;

  function automatic logic [LEN_W-1:0] eff_size(input logic [LEN_W-1:0] s);
    logic [LEN_W-1:0] r;
    r = s;
    if (r == '0) r = LEN_W'(1);
    if (r > LEN_W'(MAX_REQUEST_BYTES)) r = LEN_W'(MAX_REQUEST_BYTES);
    return r;
  endfunction

  function automatic logic [OUTST_W-1:0] eff_limit(input logic [OUTST_W-1:0] l);
    logic [OUTST_W-1:0] r;
    r = l;
    if (r == '0) r = OUTST_W'(1);
    if (r > OUTST_W'(MAX_OUTSTANDING)) r = OUTST_W'(MAX_OUTSTANDING);
    return r;
  endfunction

endpackage
`default_nettype wire

### design/dbs_ctrl.sv
`default_nettype none
module dbs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire dbs_pkg::dbs_in_t  in_data,
  input  wire dbs_pkg::dbs_sts_t sts,
  output dbs_pkg::dbs_cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_DIV_FIX,
    ST_FILL,
    ST_EMIT_DONE,
    ST_EMIT_BUSY
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.command == dbs_pkg::CMD_START) begin
            if (sts.busy) begin
              state_nxt = ST_EMIT_BUSY;
            end else if (sts.bytes_zero) begin
              state_nxt = ST_EMIT_DONE;
            end else begin
              cmd.start = 1'b1;
              state_nxt = ST_DIV;
            end
          end else if (sts.busy && sts.outst_nz) begin
            cmd.resp = 1'b1;
            if (sts.left_zero && sts.outst_one) begin
              cmd.clear_busy = 1'b1;
              state_nxt      = ST_EMIT_DONE;
            end else begin
              state_nxt = ST_FILL;
            end
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = ST_DIV_FIX;
      end
      ST_DIV_FIX: begin
        cmd.div_fix = 1'b1;
        state_nxt   = ST_FILL;
      end
      ST_FILL: begin
        if (!sts.can_issue) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.emit_req = 1'b1;
          if (sts.req_last) state_nxt = ST_IDLE;
        end
      end
      ST_EMIT_DONE: begin
        if (sts.out_free) begin
          cmd.emit_done = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_EMIT_BUSY: begin
        if (sts.out_free) begin
          cmd.emit_busy = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

### design/dbs_dp.sv
`default_nettype none
module dbs_dp (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire dbs_pkg::dbs_cmd_t                  cmd,
  output dbs_pkg::dbs_sts_t                       sts,
  input  wire dbs_pkg::dbs_in_t                   in_data,
  input  wire logic                               cfg_wr_en,
  input  wire logic [dbs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [dbs_pkg::CFG_DAT_W-1:0]      cfg_wdata,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output dbs_pkg::dbs_out_t                       out_data
);

  // configuration
  logic [dbs_pkg::LEN_W-1:0]     req_size_r;
  logic [dbs_pkg::OUTST_W-1:0]   max_outst_r;
  logic                          pim_r;

  // transfer state
  logic                          busy_r;
  logic [dbs_pkg::OUTST_W-1:0]   outst_r;
  logic [dbs_pkg::ADDR_W-1:0]    addr_r;
  logic [dbs_pkg::CNT_W-1:0]     left_r;
  logic [dbs_pkg::CNT_W-1:0]     idx_r;
  logic [dbs_pkg::CNT_W-1:0]     total_r;
  logic [dbs_pkg::LEN_W-1:0]     size_r;
  logic                          dir_r;

  // divider
  logic [dbs_pkg::LEN_W-1:0]     rem_r;
  logic [dbs_pkg::DIV_CNT_W-1:0] div_cnt_r;
  logic [dbs_pkg::LEN_W:0]       trial;
  logic [dbs_pkg::LEN_W:0]       diff;
  logic                          fits;

  logic                          out_valid_r;
  dbs_pkg::dbs_out_t             out_data_r;
  dbs_pkg::dbs_out_t             status_item;

  logic [dbs_pkg::OUTST_W-1:0]   limit;
  logic [dbs_pkg::CNT_W-1:0]     size_ext;
  logic                          left_le_size;
  logic [dbs_pkg::LEN_W-1:0]     len;

  assign limit        = dbs_pkg::eff_limit(max_outst_r);
  assign size_ext     = dbs_pkg::CNT_W'(size_r);
  assign left_le_size = (left_r <= size_ext);
  assign len          = left_le_size ? left_r[dbs_pkg::LEN_W-1:0] : size_r;

  assign trial = {rem_r, total_r[dbs_pkg::CNT_W-1]};
  assign diff  = trial - {1'b0, size_r};
  assign fits  = (trial >= {1'b0, size_r});

  always_comb begin
    sts            = '0;
    sts.busy       = busy_r;
    sts.outst_nz   = (outst_r != '0);
    sts.outst_one  = (outst_r == dbs_pkg::OUTST_W'(1));
    sts.left_zero  = (left_r == '0);
    sts.bytes_zero = (in_data.byte_count == '0);
    sts.div_last   = (div_cnt_r == dbs_pkg::DIV_CNT_W'(dbs_pkg::DIV_STEPS - 1));
    sts.can_issue  = (left_r != '0) && (outst_r < limit);
    sts.req_last   = left_le_size || (outst_r == limit - dbs_pkg::OUTST_W'(1));
    sts.out_free   = !out_valid_r || !out_stall;
  end

  always_comb begin
    status_item      = '0;
    status_item.kind = cmd.emit_done ? dbs_pkg::KIND_DONE : dbs_pkg::KIND_BUSY;
    status_item.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_size_r  <= dbs_pkg::RESET_REQUEST_SIZE;
      max_outst_r <= dbs_pkg::RESET_MAX_OUTSTANDING;
      pim_r       <= 1'b0;
      busy_r      <= 1'b0;
      outst_r     <= '0;
      addr_r      <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          dbs_pkg::CFG_REQUEST_SIZE:    req_size_r  <= cfg_wdata;
          dbs_pkg::CFG_MAX_OUTSTANDING: max_outst_r <= cfg_wdata[dbs_pkg::OUTST_W-1:0];
          dbs_pkg::CFG_TARGET_IS_PIM:   pim_r       <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (cmd.start) begin
        busy_r  <= 1'b1;
        outst_r <= '0;
        left_r  <= in_data.byte_count;
      end
      if (cmd.resp) outst_r <= outst_r - dbs_pkg::OUTST_W'(1);
      if (cmd.clear_busy) busy_r <= 1'b0;
      if (cmd.emit_req) begin
        outst_r <= outst_r + dbs_pkg::OUTST_W'(1);
        addr_r  <= addr_r + dbs_pkg::ADDR_W'(size_r);
        left_r  <= left_r - dbs_pkg::CNT_W'(len);
      end
      if (cmd.emit_req || cmd.emit_done || cmd.emit_busy) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      size_r    <= dbs_pkg::eff_size(req_size_r);
      dir_r     <= in_data.direction;
      idx_r     <= '0;
      total_r   <= in_data.byte_count;
      rem_r     <= '0;
      div_cnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r     <= fits ? diff[dbs_pkg::LEN_W-1:0] : trial[dbs_pkg::LEN_W-1:0];
      total_r   <= {total_r[dbs_pkg::CNT_W-2:0], fits};
      div_cnt_r <= div_cnt_r + dbs_pkg::DIV_CNT_W'(1);
    end
    // round the quotient up when a short final request remains
    if (cmd.div_fix) total_r <= total_r + dbs_pkg::CNT_W'(rem_r != '0);
    if (cmd.emit_req) begin
      idx_r                      <= idx_r + dbs_pkg::CNT_W'(1);
      out_data_r.kind            <= dbs_pkg::KIND_REQ;
      out_data_r.request_dir     <= dir_r;
      out_data_r.request_address <= addr_r;
      out_data_r.request_length  <= len;
      out_data_r.request_index   <= idx_r;
      out_data_r.request_total   <= total_r;
      out_data_r.destination     <= pim_r;
      out_data_r.last            <= sts.req_last;
    end else if (cmd.emit_done || cmd.emit_busy) begin
      out_data_r <= status_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

### design/dma_burst_splitter.sv
// a start divides its byte count by the request size, one quotient bit per cycle,
// before its first request; then requests leave one per cycle, while out_stall is low,
// up to the limit; results of a response, rejected or empty start pass a state register first
// throughput: one item at a time; the next item is taken once the last result is queued
// reset: synchronous active-low rst_n clears the transfer state and address counter
// and loads request_size 64, max_outstanding 16, target_is_pim 0
`default_nettype none
module dma_burst_splitter (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire dbs_pkg::dbs_in_t              in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output dbs_pkg::dbs_out_t                  out_data,
  input  wire logic                          cfg_wr_en,
  input  wire logic [dbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dbs_pkg::CFG_DAT_W-1:0] cfg_wdata
);

  dbs_pkg::dbs_cmd_t cmd;
  dbs_pkg::dbs_sts_t sts;

  dbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .sts      (sts),
    .cmd      (cmd)
  );

  dbs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

### design/dbs_checker.sv
`default_nettype none
`include "dma_burst_splitter_assert.svh"
module dbs_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire dbs_pkg::dbs_out_t out_data
);

  `DBS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  `DBS_ASSERT_NOW(a_kind_legal, out_valid, out_data.kind == dbs_pkg::KIND_REQ || out_data.kind == dbs_pkg::KIND_DONE || out_data.kind == dbs_pkg::KIND_BUSY)

  `DBS_ASSERT_NOW(a_status_alone, out_valid && out_data.kind != dbs_pkg::KIND_REQ, out_data.last && out_data.request_address == '0 && out_data.request_total == '0)

  `DBS_ASSERT_NOW(a_req_sane, out_valid && out_data.kind == dbs_pkg::KIND_REQ, out_data.request_length != '0 && out_data.request_index < out_data.request_total)

endmodule

bind dma_burst_splitter dbs_checker u_dbs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

### verif/dbs_burst_checker.sv
`timescale 1ns / 1ps
module dbs_burst_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  dbs_pkg::dbs_in_t              in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  dbs_pkg::dbs_out_t             out_data,
  input  logic                          cfg_wr_en,
  input  logic [dbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dbs_pkg::CFG_DAT_W-1:0] cfg_wdata,
  output int                            fail_count,
  output int                            results_left,
  output int                            results_seen,
  output logic                          xfer_open
);
  import dbs_pkg::*;

  logic [LEN_W-1:0]   size_reg;
  logic [OUTST_W-1:0] limit_reg;
  logic               pim_reg;

  logic [ADDR_W-1:0]  addr_ctr;
  logic [CNT_W-1:0]   bytes_rem;
  logic [OUTST_W-1:0] window;
  logic [CNT_W-1:0]   req_idx;
  logic [CNT_W-1:0]   req_cnt;
  logic               xfer_dir;
  logic [LEN_W-1:0]   burst_len;

  dbs_out_t due_results[$];
  dbs_out_t batch_q[$];

  function automatic dbs_out_t blank_result(input logic [1:0] k);
    dbs_out_t r;
    r = '0;
    r.kind = k;
    return r;
  endfunction

  task refill_window();
    logic [OUTST_W-1:0] cap;
    logic [LEN_W-1:0]   len;
    dbs_out_t           r;
    cap = (limit_reg == '0) ? OUTST_W'(1) : limit_reg;
    while (bytes_rem != '0 && window < cap) begin
      len = (bytes_rem < CNT_W'(burst_len)) ? LEN_W'(bytes_rem) : burst_len;
      r = '0;
      r.kind            = KIND_REQ;
      r.request_dir     = xfer_dir;
      r.request_address = addr_ctr;
      r.request_length  = len;
      r.request_index   = req_idx;
      r.request_total   = req_cnt;
      r.destination     = pim_reg;
      batch_q.push_back(r);
      addr_ctr  = addr_ctr + ADDR_W'(burst_len);
      req_idx   = req_idx + CNT_W'(1);
      window    = window + OUTST_W'(1);
      bytes_rem = bytes_rem - CNT_W'(len);
    end
  endtask

  task accept_item(input dbs_in_t item);
    dbs_out_t         r;
    logic [LEN_W-1:0] es;
    batch_q.delete();
    if (item.command == CMD_START) begin
      if (xfer_open) begin
        batch_q.push_back(blank_result(KIND_BUSY));
      end else if (item.byte_count == '0) begin
        batch_q.push_back(blank_result(KIND_DONE));
      end else begin
        es = size_reg;
        if (es == '0) es = LEN_W'(1);
        if (es > LEN_W'(MAX_REQUEST_BYTES)) es = LEN_W'(MAX_REQUEST_BYTES);
        burst_len = es;
        req_cnt   = CNT_W'((64'(item.byte_count) + 64'(es) - 64'd1) / 64'(es));
        bytes_rem = item.byte_count;
        req_idx   = '0;
        window    = '0;
        xfer_dir  = item.direction;
        xfer_open = 1'b1;
        refill_window();
      end
    end else if (xfer_open && window != '0) begin
      window = window - OUTST_W'(1);
      if (bytes_rem == '0 && window == '0) begin
        xfer_open = 1'b0;
        batch_q.push_back(blank_result(KIND_DONE));
      end else begin
        refill_window();
      end
    end
    if (batch_q.size() > 0) begin
      r = batch_q[batch_q.size()-1];
      r.last = 1'b1;
      batch_q[batch_q.size()-1] = r;
      foreach (batch_q[i]) due_results.push_back(batch_q[i]);
    end
  endtask

  task check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: result %0d %s expected 0x%0h actual 0x%0h",
               $time, results_seen, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    dbs_out_t want;
    if (!rst_n) begin
      size_reg     = RESET_REQUEST_SIZE;
      limit_reg    = RESET_MAX_OUTSTANDING;
      pim_reg      = 1'b0;
      addr_ctr     = '0;
      bytes_rem    = '0;
      window       = '0;
      req_idx      = '0;
      req_cnt      = '0;
      xfer_dir     = 1'b0;
      xfer_open    = 1'b0;
      burst_len    = '0;
      fail_count   = 0;
      results_seen = 0;
      due_results.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_REQUEST_SIZE:    size_reg = cfg_wdata;
          CFG_MAX_OUTSTANDING: limit_reg = cfg_wdata[OUTST_W-1:0];
          CFG_TARGET_IS_PIM:   pim_reg = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (due_results.size() == 0) begin
          $display("%0t: result %0d expected none actual kind %0d address 0x%0h",
                   $time, results_seen, out_data.kind, out_data.request_address);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          check_field("kind", 64'(want.kind), 64'(out_data.kind));
          check_field("request_dir", 64'(want.request_dir), 64'(out_data.request_dir));
          check_field("request_address", want.request_address, out_data.request_address);
          check_field("request_length", 64'(want.request_length),
                      64'(out_data.request_length));
          check_field("request_index", 64'(want.request_index), 64'(out_data.request_index));
          check_field("request_total", 64'(want.request_total), 64'(out_data.request_total));
          check_field("destination", 64'(want.destination), 64'(out_data.destination));
          check_field("last", 64'(want.last), 64'(out_data.last));
        end
      end
      if (in_valid && !in_stall) accept_item(in_data);
    end
    results_left = due_results.size();
  end

endmodule

### verif/dma_burst_splitter_tb.sv
`timescale 1ns / 1ps
module dma_burst_splitter_tb;
  import dbs_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 3000;
  localparam int ITEM_TARGET   = 220;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  dbs_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b1;
  dbs_out_t             out_data;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  int   fail_count;
  int   results_left;
  int   results_seen;
  logic xfer_open;

  bit               steady = 1'b0;
  int               items_sent = 0;
  int               starts_sent = 0;
  int               resps_sent = 0;
  int               settings_used = 0;
  int               quiet_cycles = 0;
  logic [LEN_W-1:0] size_now = RESET_REQUEST_SIZE;

  always #5 clk = ~clk;

  dma_burst_splitter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  dbs_burst_checker burst_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .results_left (results_left),
    .results_seen (results_seen),
    .xfer_open    (xfer_open)
  );

  function automatic int pick_gap();
    return steady ? 0 : int'($urandom_range(0, 19));
  endfunction

  function automatic logic [CFG_DAT_W-1:0] pick_size();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return CFG_DAT_W'(1);
      2: return CFG_DAT_W'(MAX_REQUEST_BYTES);
      3: return '1;
      4: return CFG_DAT_W'($urandom_range(2, 64));
      default: return CFG_DAT_W'($urandom_range(0, 8191));
    endcase
  endfunction

  function automatic logic [CFG_DAT_W-1:0] pick_limit();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return CFG_DAT_W'(1);
      2: return CFG_DAT_W'(MAX_OUTSTANDING);
      3: return CFG_DAT_W'($urandom_range(2, 8));
      default: return CFG_DAT_W'($urandom_range(0, 63));
    endcase
  endfunction

  // byte count that splits into nreq requests at the current size
  function automatic logic [CNT_W-1:0] bytes_for(input int nreq);
    int unit;
    unit = (size_now == '0) ? 1 :
           ((size_now > LEN_W'(MAX_REQUEST_BYTES)) ? MAX_REQUEST_BYTES : int'(size_now));
    return CNT_W'((nreq - 1) * unit + int'($urandom_range(1, unit)));
  endfunction

  task automatic send_item(input logic cmd, input logic dir, input logic [CNT_W-1:0] bytes);
    int gap;
    gap = pick_gap();
    in_valid = 1'b0;
    repeat (gap) @(negedge clk);
    in_valid           = 1'b1;
    in_data.command    = cmd;
    in_data.direction  = dir;
    in_data.byte_count = bytes;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_start(input logic dir, input logic [CNT_W-1:0] bytes);
    send_item(CMD_START, dir, bytes);
    items_sent++;
    starts_sent++;
  endtask

  task automatic send_resp();
    if (xfer_open) items_sent++;
    resps_sent++;
    send_item(CMD_RESP, 1'($urandom), $urandom);
  endtask

  task automatic settle();
    while (results_left != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    if (idx == CFG_REQUEST_SIZE) size_now = val;
  endtask

  task automatic run_transfer(input logic dir, input logic [CNT_W-1:0] bytes, input bit twist);
    send_start(dir, bytes);
    // settings change while requests are still outstanding
    if (twist && xfer_open) begin
      settle();
      write_reg(CFG_MAX_OUTSTANDING, CFG_DAT_W'($urandom_range(0, 4)));
      write_reg(CFG_TARGET_IS_PIM, CFG_DAT_W'($urandom_range(0, 1)));
      if ($urandom_range(0, 1)) write_reg(CFG_REQUEST_SIZE, pick_size());
    end
    while (xfer_open) begin
      if ($urandom_range(0, 7) == 0) send_start(1'($urandom), $urandom);
      send_resp();
    end
  endtask

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : result_taker
    int gap;
    @(negedge clk);
    forever begin
      gap = pick_gap();
      out_stall = (gap > 0);
      repeat (gap) @(negedge clk);
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed part, first at reset settings
    send_resp();
    send_start(1'b0, '0);
    run_transfer(1'b1, 32'd1, 1'b0);
    send_start(1'b0, 32'd200);
    send_start(1'b1, 32'hFFFF_FFFF);
    while (xfer_open) send_resp();
    send_resp();
    settle();
    write_reg(CFG_REQUEST_SIZE, '0);
    write_reg(CFG_MAX_OUTSTANDING, '0);
    write_reg(CFG_TARGET_IS_PIM, CFG_DAT_W'(1));
    run_transfer(1'b0, 32'd3, 1'b0);
    settle();
    write_reg(CFG_REQUEST_SIZE, CFG_DAT_W'(MAX_REQUEST_BYTES));
    write_reg(CFG_MAX_OUTSTANDING, CFG_DAT_W'(MAX_OUTSTANDING));
    write_reg(CFG_TARGET_IS_PIM, '0);
    run_transfer(1'b1, 32'd4097, 1'b0);
    settle();
    write_reg(CFG_REQUEST_SIZE, '1);
    run_transfer(1'b0, 32'd5000, 1'b0);
    settings_used = 4;

    // random part
    while (items_sent < ITEM_TARGET) begin
      settle();
      if ($urandom_range(0, 1)) write_reg(CFG_REQUEST_SIZE, pick_size());
      if ($urandom_range(0, 1)) write_reg(CFG_MAX_OUTSTANDING, pick_limit());
      if ($urandom_range(0, 1)) write_reg(CFG_TARGET_IS_PIM, CFG_DAT_W'($urandom_range(0, 1)));
      settings_used++;
      steady = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 9))
          0: send_start(1'($urandom), '0);
          1: send_resp();
          default: run_transfer(1'($urandom),
                                bytes_for($urandom_range(1, ($urandom_range(0, 3) == 0) ? 63 : 12)),
                                $urandom_range(0, 5) == 0);
        endcase
      end
    end

    // largest transfer at the smallest size, left running
    settle();
    steady = 1'b0;
    write_reg(CFG_REQUEST_SIZE, CFG_DAT_W'(1));
    write_reg(CFG_MAX_OUTSTANDING, CFG_DAT_W'(MAX_OUTSTANDING));
    write_reg(CFG_TARGET_IS_PIM, CFG_DAT_W'(1));
    settings_used++;
    send_start(1'b1, 32'hFFFF_FFFF);
    repeat (5) send_resp();
    send_start(1'b0, 32'h8000_0000);
    settle();

    $display("covered %0d starts and %0d responses over %0d register settings",
             starts_sent, resps_sent, settings_used);
    $display("%0d results checked against the predicted request stream", results_seen);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### dma_burst_splitter.f
+incdir+design
design/dbs_pkg.sv
design/dbs_ctrl.sv
design/dbs_dp.sv
design/dma_burst_splitter.sv
design/dbs_checker.sv
verif/dbs_burst_checker.sv
verif/dma_burst_splitter_tb.sv
